FILE: design/rcoq_pkg.sv
// Package for the row/column occupancy range query block.
// Holds the field widths, the action codes and the line bank control struct.
// Depends on nothing; every other design file uses it.
package rcoq_pkg;

   // Default grid size: number of rows and of columns.
   localparam int BOARD_SIZE_DEFAULT = 64;

   // Fixed widths of the transaction fields.
   localparam int IDX_W    = 6;
   localparam int ACTION_W = 2;

   // Action codes carried by a request transaction.
   typedef enum logic [ACTION_W-1:0] {
      ACT_PLACE  = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Control handed to one line bank (rows or columns) for one transaction.
   typedef struct packed {
      logic             inc;
      logic             dec;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } bank_ctl_type;

endpackage

FILE: design/rcoq_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on rcoq_pkg for the field widths.

// Request channel: place, remove or query transactions.
interface rcoq_req_if;
   logic                         valid;
   logic                         ready;
   logic [rcoq_pkg::ACTION_W-1:0] action;
   logic [rcoq_pkg::IDX_W-1:0]    row;
   logic [rcoq_pkg::IDX_W-1:0]    col;
   logic [rcoq_pkg::IDX_W-1:0]    row_high;
   logic [rcoq_pkg::IDX_W-1:0]    col_high;

   modport source (output valid, action, row, col, row_high, col_high, input ready);
   modport sink   (input valid, action, row, col, row_high, col_high, output ready);
endinterface

// Response channel: one covered flag per query transaction.
interface rcoq_rsp_if;
   logic valid;
   logic ready;
   logic covered;

   modport source (output valid, covered, input ready);
   modport sink   (input valid, covered, output ready);
endinterface

FILE: design/rcoq_line_bank.sv
// One bank of per-line occupancy counters (all rows or all columns).
// Each line is a saturating counter cell that watches for its own index.
// Depends on rcoq_pkg for the control struct and index width.
module rcoq_line_bank #(
   parameter int BOARD_SIZE = rcoq_pkg::BOARD_SIZE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rcoq_pkg::bank_ctl_type ctl,
   output logic                   has_free
);

   localparam int CNT_W = $clog2(BOARD_SIZE + 1);
   localparam int LW    = $clog2(BOARD_SIZE);
   localparam int CMP_W = ((LW > rcoq_pkg::IDX_W) ? LW : rcoq_pkg::IDX_W) + 1;

   logic [CMP_W-1:0]      idx_ext;
   logic [CMP_W-1:0]      lo_ext;
   logic [CMP_W-1:0]      hi_ext;
   logic [BOARD_SIZE-1:0] free_mask;

   assign idx_ext = CMP_W'(ctl.idx);
   assign lo_ext  = CMP_W'(ctl.lo);
   assign hi_ext  = CMP_W'(ctl.hi);

   // One counter cell per line.
   for (genvar i = 0; i < BOARD_SIZE; i++) begin : g_line
      logic [CNT_W-1:0] cnt_ff;
      logic [CNT_W-1:0] cnt_in;
      logic             hit;
      logic             in_range;

      assign hit      = (idx_ext == CMP_W'(i));
      assign in_range = (lo_ext <= CMP_W'(i)) && (CMP_W'(i) <= hi_ext);

      // Saturating step: stops at the grid size going up and at zero going down.
      always_comb begin
         cnt_in = cnt_ff;
         if (hit && ctl.inc && (cnt_ff != CNT_W'(BOARD_SIZE))) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else if (hit && ctl.dec && (cnt_ff != '0)) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_in;
         end
      end

      // A line is free when its counter is zero and it lies in the query range.
      assign free_mask[i] = (cnt_ff == '0) && in_range;
   end

   assign has_free = |free_mask;

endmodule

FILE: design/row_col_occupancy_range_query.sv
// Top level of the row/column occupancy range query block.
// Depends on rcoq_pkg, the rcoq_req_if/rcoq_rsp_if interfaces and rcoq_line_bank.
//
// Usage:
//   The req channel carries place, remove and query transactions. A place
//   raises the counters of its row and its column, a remove lowers them, and
//   a query returns one rsp transaction whose covered flag is 0 only when
//   some row in the row range and some column in the column range are both
//   free. Place, remove and the unused action code give no response.
//   A query is held in the input register and then in the response register,
//   which drives rsp. Throughput: one transaction per cycle, except that a
//   query waits while the response register is full and stalled; the counter
//   cells update and the range masks reduce combinationally between the two.
//   Reset (synchronous, active high) clears all counters and empties both
//   registers; the block accepts transactions in the first cycle after it.
//   When the receiver stalls, the response waits in the output register;
//   place and remove transactions still flow through, and a query waits in
//   the input register, so req.ready drops only while a query is held there.
module row_col_occupancy_range_query #(
   parameter int BOARD_SIZE = rcoq_pkg::BOARD_SIZE_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rcoq_req_if.sink   req,
   rcoq_rsp_if.source rsp
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [rcoq_pkg::ACTION_W-1:0] s1_action_ff;
   logic [rcoq_pkg::IDX_W-1:0]    s1_row_ff;
   logic [rcoq_pkg::IDX_W-1:0]    s1_col_ff;
   logic [rcoq_pkg::IDX_W-1:0]    s1_row_high_ff;
   logic [rcoq_pkg::IDX_W-1:0]    s1_col_high_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic                          out_covered_ff;
   logic                          out_covered_in;
   logic                          req_accept;
   logic                          s1_is_query;
   logic                          s1_adv;
   logic                          row_free;
   logic                          col_free;
   rcoq_pkg::bank_ctl_type        row_ctl;
   rcoq_pkg::bank_ctl_type        col_ctl;

   // Stage advance: a query needs room in the response register.
   assign s1_is_query = (s1_action_ff == rcoq_pkg::ACT_QUERY);
   assign s1_adv      = s1_valid_ff && (!s1_is_query || !out_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_adv;
   assign req_accept  = req.valid && req.ready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff   <= req.action;
         s1_row_ff      <= req.row;
         s1_col_ff      <= req.col;
         s1_row_high_ff <= req.row_high;
         s1_col_high_ff <= req.col_high;
      end
   end

   // Counter bank controls; counters move only when the stage advances.
   always_comb begin
      row_ctl.inc = s1_adv && (s1_action_ff == rcoq_pkg::ACT_PLACE);
      row_ctl.dec = s1_adv && (s1_action_ff == rcoq_pkg::ACT_REMOVE);
      row_ctl.idx = s1_row_ff;
      row_ctl.lo  = s1_row_ff;
      row_ctl.hi  = s1_row_high_ff;
      col_ctl.inc = row_ctl.inc;
      col_ctl.dec = row_ctl.dec;
      col_ctl.idx = s1_col_ff;
      col_ctl.lo  = s1_col_ff;
      col_ctl.hi  = s1_col_high_ff;
   end

   rcoq_line_bank #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_row_bank (
      .clock    (clock),
      .reset    (reset),
      .ctl      (row_ctl),
      .has_free (row_free)
   );

   rcoq_line_bank #(
      .BOARD_SIZE(BOARD_SIZE)
   ) u_col_bank (
      .clock    (clock),
      .reset    (reset),
      .ctl      (col_ctl),
      .has_free (col_free)
   );

   // Response register: loads a query result, holds while the receiver stalls.
   assign out_valid_in   = (out_valid_ff && !rsp.ready) || (s1_adv && s1_is_query);
   assign out_covered_in = !(row_free && col_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_is_query) begin
         out_covered_ff <= out_covered_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.covered = out_covered_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for row_col_occupancy_range_query.
// Depends on rcoq_pkg, the rcoq_req_if/rcoq_rsp_if interfaces and the block itself.
module tb_top;

   localparam int GRID         = rcoq_pkg::BOARD_SIZE_DEFAULT;
   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic [rcoq_pkg::IDX_W-1:0] idx_type;

   // One pending request transaction; wait_drain holds it back until no
   // response is outstanding.
   typedef struct {
      rcoq_pkg::action_type act;
      idx_type              row;
      idx_type              col;
      idx_type              row_high;
      idx_type              col_high;
      bit                   wait_drain;
   } occ_req_type;

   logic clock;
   logic reset;

   rcoq_req_if req_ch ();
   rcoq_rsp_if rsp_ch ();

   row_col_occupancy_range_query uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   occ_req_type pending_reqs[$];
   bit          covered_exp_q[$];
   logic [6:0]  row_count [GRID];
   logic [6:0]  col_count [GRID];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_gap;
   int          stall_gap;
   int          hold_left;
   bit          hold_done;
   int          results_seen;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] ERROR: %s", $realtime, what);
   endtask

   // True when some line of the selected bank in lo..hi has a zero count.
   function automatic bit has_free_line(input bit col_bank, input idx_type lo,
                                        input idx_type hi);
      bit found;
      found = 1'b0;
      for (int i = 0; i < GRID; i++) begin
         if (i >= lo && i <= hi) begin
            if (col_bank ? (col_count[i] == 0) : (row_count[i] == 0)) found = 1'b1;
         end
      end
      return found;
   endfunction

   // Update the counters for an accepted transaction and queue the covered flag
   // that a query must return.
   task automatic track_occupancy(input occ_req_type it);
      bit row_free;
      bit col_free;
      case (it.act)
         rcoq_pkg::ACT_PLACE: begin
            if (row_count[it.row] < GRID) row_count[it.row]++;
            if (col_count[it.col] < GRID) col_count[it.col]++;
         end
         rcoq_pkg::ACT_REMOVE: begin
            if (row_count[it.row] > 0) row_count[it.row]--;
            if (col_count[it.col] > 0) col_count[it.col]--;
         end
         rcoq_pkg::ACT_QUERY: begin
            row_free = has_free_line(1'b0, it.row, it.row_high);
            col_free = has_free_line(1'b1, it.col, it.col_high);
            covered_exp_q.push_back(!(row_free && col_free));
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input rcoq_pkg::action_type act, input idx_type r,
                            input idx_type c, input idx_type rh,
                            input idx_type ch, input bit drain = 1'b0);
      occ_req_type it;
      it.act        = act;
      it.row        = r;
      it.col        = c;
      it.row_high   = rh;
      it.col_high   = ch;
      it.wait_drain = drain;
      pending_reqs.push_back(it);
   endtask

   // Drive one line pair past full and back below empty, querying along the way.
   task automatic push_saturation_burst();
      idx_type r;
      idx_type c;
      r = idx_type'($urandom);
      c = idx_type'($urandom);
      for (int k = 0; k < GRID + 2; k++) begin
         push_item(rcoq_pkg::ACT_PLACE, r, c, idx_type'($urandom), idx_type'($urandom));
         if (k % 16 == 15) push_item(rcoq_pkg::ACT_QUERY, r, c, r, c);
      end
      for (int k = 0; k < GRID + 4; k++) begin
         push_item(rcoq_pkg::ACT_REMOVE, r, c, idx_type'($urandom), idx_type'($urandom));
         if (k % 16 == 15) push_item(rcoq_pkg::ACT_QUERY, r, c, r, c);
      end
      push_item(rcoq_pkg::ACT_QUERY, r, c, r, c);
   endtask

   // Request driver: offers the head of the pending queue, with random gaps.
   always @(posedge clock) begin
      bit next_valid;
      occ_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
         for (int i = 0; i < GRID; i++) begin
            row_count[i] = '0;
            col_count[i] = '0;
         end
      end else begin
         next_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            track_occupancy(pending_reqs.pop_front());
            next_valid = 1'b0;
            if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 12);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].wait_drain && covered_exp_q.size() != 0)) begin
               nxt = pending_reqs[0];
               req_ch.action   <= nxt.act;
               req_ch.row      <= nxt.row;
               req_ch.col      <= nxt.col;
               req_ch.row_high <= nxt.row_high;
               req_ch.col_high <= nxt.col_high;
               next_valid = 1'b1;
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   // Long receiver hold-off, counted in cycles once enough responses have come.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each transaction and drives ready, with random
   // stalls and the long hold-off that backs the block up.
   always @(posedge clock) begin
      bit next_ready;
      bit want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_gap     = 0;
         results_seen <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (covered_exp_q.size() == 0) begin
               report_mismatch($sformatf("response with none expected, covered=%b",
                                         rsp_ch.covered));
            end else begin
               want = covered_exp_q.pop_front();
               if (rsp_ch.covered !== want)
                  report_mismatch($sformatf("covered mismatch: got %b, want %b",
                                            rsp_ch.covered, want));
            end
         end
         if (hold_left > 0) begin
            next_ready = 1'b0;
         end else if (stall_gap > 0) begin
            stall_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
               stall_gap = $urandom_range(1, 12);
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus: directed transactions, then random segments, then the wrap-up.
   initial begin
      int made;
      int burst_no;
      int win_lo;
      int win_size;
      int w_place;
      int w_remove;
      int roll;
      bit drain_next;
      idx_type r;
      idx_type c;
      idx_type rh;
      idx_type ch;

      reset = 1'b1;

      // Directed part: empty grid, removal from empty lines, edge indices,
      // empty ranges and the unused action code.
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd0,  6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_REMOVE, 6'd0,  6'd0,  6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd0,  6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_PLACE,  6'd0,  6'd0,  6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_PLACE,  6'd63, 6'd63, 6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd5,  6'd0,  6'd5);
      push_item(rcoq_pkg::ACT_QUERY,  6'd5,  6'd63, 6'd5,  6'd63);
      push_item(rcoq_pkg::ACT_QUERY,  6'd1,  6'd1,  6'd1,  6'd1);
      push_item(rcoq_pkg::ACT_QUERY,  6'd5,  6'd1,  6'd2,  6'd1);
      push_item(rcoq_pkg::ACT_QUERY,  6'd1,  6'd40, 6'd1,  6'd20);
      push_item(rcoq_pkg::ACT_QUERY,  6'd63, 6'd0,  6'd0,  6'd63);
      push_item(rcoq_pkg::ACT_NONE,   6'd63, 6'd63, 6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_QUERY,  6'd63, 6'd63, 6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_REMOVE, 6'd63, 6'd63, 6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_QUERY,  6'd63, 6'd63, 6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_REMOVE, 6'd63, 6'd63, 6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_PLACE,  6'd63, 6'd0,  6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd0,  6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd0,  6'd0,  6'd63);
      push_item(rcoq_pkg::ACT_NONE,   6'd0,  6'd0,  6'd0,  6'd0);
      push_item(rcoq_pkg::ACT_REMOVE, 6'd0,  6'd0,  6'd63, 6'd63);
      push_item(rcoq_pkg::ACT_QUERY,  6'd0,  6'd0,  6'd63, 6'd0);

      // Random part: segments confined to a window of lines so that ranges
      // fill up and drain, with occasional saturation bursts and noise.
      made       = 0;
      burst_no   = 0;
      drain_next = 1'b1;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0:       win_size = 2;
            1:       win_size = 4;
            2:       win_size = 8;
            3:       win_size = 16;
            default: win_size = GRID;
         endcase
         win_lo   = $urandom_range(0, GRID - win_size);
         w_place  = $urandom_range(1, 6);
         w_remove = $urandom_range(1, 6);
         for (int k = 0; k < 40; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               push_item(rcoq_pkg::ACT_NONE, idx_type'($urandom), idx_type'($urandom),
                         idx_type'($urandom), idx_type'($urandom));
               continue;
            end
            roll = $urandom_range(0, w_place + w_remove + 2);
            r    = idx_type'(win_lo + $urandom_range(0, win_size - 1));
            c    = idx_type'(win_lo + $urandom_range(0, win_size - 1));
            if (roll < w_place) begin
               push_item(rcoq_pkg::ACT_PLACE, r, c, idx_type'($urandom),
                         idx_type'($urandom), drain_next);
            end else if (roll < w_place + w_remove) begin
               push_item(rcoq_pkg::ACT_REMOVE, r, c, idx_type'($urandom),
                         idx_type'($urandom), drain_next);
            end else begin
               case ($urandom_range(0, 15))
                  0: begin
                     r  = idx_type'($urandom);
                     c  = idx_type'($urandom);
                     rh = idx_type'($urandom);
                     ch = idx_type'($urandom);
                  end
                  1: begin
                     r  = idx_type'($urandom_range(1, GRID - 1));
                     rh = idx_type'($urandom_range(0, r - 1));
                     ch = idx_type'(c + $urandom_range(0, win_lo + win_size - 1 - c));
                  end
                  2: begin
                     c  = idx_type'($urandom_range(1, GRID - 1));
                     ch = idx_type'($urandom_range(0, c - 1));
                     rh = idx_type'(r + $urandom_range(0, win_lo + win_size - 1 - r));
                  end
                  default: begin
                     rh = idx_type'(r + $urandom_range(0, win_lo + win_size - 1 - r));
                     ch = idx_type'(c + $urandom_range(0, win_lo + win_size - 1 - c));
                  end
               endcase
               push_item(rcoq_pkg::ACT_QUERY, r, c, rh, ch, drain_next);
            end
            drain_next = 1'b0;
            made++;
            if (made == RANDOM_ITEMS / 2) drain_next = 1'b1;
         end
         if (burst_no < 2 && made >= (burst_no + 1) * RANDOM_ITEMS / 3) begin
            push_saturation_burst();
            burst_no++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wrap-up: everything sent, every response back, then a short drain.
      while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clock);
      while (covered_exp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rcoq_pkg.sv
design/rcoq_if.sv
design/rcoq_line_bank.sv
design/row_col_occupancy_range_query.sv
tb/tb_top.sv
